// ===== sv/z_order_code_unit_macros.svh =====
// Assertion macros used by the Z-order code unit port checker.
`ifndef Z_ORDER_CODE_UNIT_MACROS_SVH
`define Z_ORDER_CODE_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ZOC_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("z_order_code_unit: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define ZOC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("z_order_code_unit: next-cycle check failed");

`endif

// ===== sv/zoc_pkg.sv =====
// Package: opcodes, masks, result type and bit shuffle functions for the Z-order unit.
package zoc_pkg;

  localparam int unsigned CodeWidth  = 32;
  localparam int unsigned CoordWidth = 16;

  typedef enum logic [1:0] {
    OP_ENCODE   = 2'd0,
    OP_DECODE   = 2'd1,
    OP_SPLIT    = 2'd2,
    OP_RESERVED = 2'd3
  } zoc_op_t;

  localparam logic [CodeWidth-1:0] MaskOdd  = 32'hAAAA_AAAA;
  localparam logic [CodeWidth-1:0] MaskEven = 32'h5555_5555;
  localparam logic [CodeWidth-1:0] Mask8    = 32'h00FF_00FF;
  localparam logic [CodeWidth-1:0] Mask4    = 32'h0F0F_0F0F;
  localparam logic [CodeWidth-1:0] Mask2    = 32'h3333_3333;
  localparam logic [CodeWidth-1:0] Mask16   = 32'h0000_FFFF;

  typedef struct packed {
    logic [CodeWidth-1:0] result_a;
    logic [CodeWidth-1:0] result_b;
    logic                 codes_equal;
  } zoc_result_t;

  // Spread a 16-bit coordinate onto the even bit positions.
  function automatic logic [CodeWidth-1:0] spread16(input logic [CoordWidth-1:0] c);
    logic [CodeWidth-1:0] v;
    v = {{(CodeWidth-CoordWidth){1'b0}}, c};
    v = (v ^ (v << 8)) & Mask8;
    v = (v ^ (v << 4)) & Mask4;
    v = (v ^ (v << 2)) & Mask2;
    v = (v ^ (v << 1)) & MaskEven;
    return v;
  endfunction

  // Gather the even bit positions back into a 16-bit coordinate.
  function automatic logic [CodeWidth-1:0] gather16(input logic [CodeWidth-1:0] code);
    logic [CodeWidth-1:0] v;
    v = code & MaskEven;
    v = (v ^ (v >> 1)) & Mask2;
    v = (v ^ (v >> 2)) & Mask4;
    v = (v ^ (v >> 4)) & Mask8;
    v = (v ^ (v >> 8)) & Mask16;
    return v;
  endfunction

endpackage

// ===== sv/zoc_core.sv =====
// Combinational core: encode, decode and LITMAX/BIGMIN split of one item.
module zoc_core (
  input  zoc_pkg::zoc_op_t                 opcode,
  input  logic [zoc_pkg::CodeWidth-1:0]    operand_a,
  input  logic [zoc_pkg::CodeWidth-1:0]    operand_b,
  output zoc_pkg::zoc_result_t             result
);
  import zoc_pkg::*;

  logic [CodeWidth-1:0] diff;
  logic [CodeWidth-1:0] smear;
  logic [CodeWidth-1:0] split_bit;
  logic [CodeWidth-1:0] dim;
  logic [CodeWidth-1:0] keep;
  logic [CodeWidth-1:0] lower;

  // Smear the top differing bit downward; its edge marks the split bit
  always_comb begin
    diff      = operand_a ^ operand_b;
    smear     = diff;
    smear     = smear | (smear >> 1);
    smear     = smear | (smear >> 2);
    smear     = smear | (smear >> 4);
    smear     = smear | (smear >> 8);
    smear     = smear | (smear >> 16);
    split_bit = smear & ~(smear >> 1);
    dim       = (|(split_bit & MaskOdd)) ? MaskOdd : MaskEven;
    keep      = ~dim | ~smear;
    lower     = (smear >> 1) & dim;
  end

  // Select the result by opcode
  always_comb begin
    result = '0;
    case (opcode)
      OP_ENCODE: begin
        result.result_a = (spread16(operand_a[CoordWidth-1:0]) << 1)
                        | spread16(operand_b[CoordWidth-1:0]);
      end
      OP_DECODE: begin
        result.result_a = gather16(operand_a >> 1);
        result.result_b = gather16(operand_a);
      end
      OP_SPLIT: begin
        if (diff == '0) begin
          result.codes_equal = 1'b1;
        end else begin
          result.result_a = (operand_b & keep) | lower;
          result.result_b = (operand_a & keep) | split_bit;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ===== sv/z_order_code_unit.sv =====
// Top level of the Z-order code unit: input register, core and result register.
// Takes one item per clock while s_tready is high and returns one result item per item,
// passing each accepted item through the input register and then the result register, with the
// encode/decode/split logic between them. The unit holds no state between items;
// a stalled result holds in the result register while the input register still
// takes a new item, and back-pressure reaches s_tready only when both are full.
module z_order_code_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // result_a [31:0], result_b [63:32]
  output logic [0:0]  m_tuser    // codes_equal [0]
);
  import zoc_pkg::*;

  logic                 in_valid;
  zoc_op_t              in_opcode;
  logic [CodeWidth-1:0] in_operand_a;
  logic [CodeWidth-1:0] in_operand_b;
  logic                 out_valid;
  zoc_result_t          out_result;
  zoc_result_t          core_result;
  logic                 out_free;
  logic                 advance;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Capture an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_opcode    <= zoc_op_t'(s_tuser);
      in_operand_a <= s_tdata[CodeWidth-1:0];
      in_operand_b <= s_tdata[2*CodeWidth-1:CodeWidth];
    end
  end

  zoc_core u_core (
    .opcode    (in_opcode),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .result    (core_result)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.result_b, out_result.result_a};
  assign m_tuser  = out_result.codes_equal;

endmodule

// ===== sv/zoc_checker.sv =====
// Port-level checker for the Z-order code unit, bound to the top level.
`include "z_order_code_unit_macros.svh"

module zoc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // A stalled result keeps its payload
  `ZOC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // Equal split codes give zero results
  `ZOC_ASSERT_SAME(a_equal_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == 64'd0)
  // An empty output side never stalls the input side
  `ZOC_ASSERT_SAME(a_ready_empty, clk, rst, !m_tvalid, s_tready)
  // An accepted item passes the input and result registers into a valid result when nothing stalls
  `ZOC_ASSERT_NEXT(a_latency, clk, rst, s_tvalid && s_tready && !m_tvalid, ##1 m_tvalid)

endmodule

bind z_order_code_unit zoc_checker u_zoc_checker (.*);

// ===== sim/z_order_code_checker.sv =====
// Checker for the Z-order code unit: predicts each result item and compares it.
module z_order_code_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // result_a [31:0], result_b [63:32]
  input  logic [0:0]  m_tuser,   // codes_equal [0]
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import zoc_pkg::*;

  zoc_result_t pending_results[$];
  int          error_tally;

  // Work out the result item of one input item, bit by bit.
  function automatic zoc_result_t zorder_result(input zoc_op_t op,
                                                input logic [31:0] a,
                                                input logic [31:0] b);
    zoc_result_t r;
    logic [31:0] diff, bit_at, above, below, dim, keep;
    int          p;
    r = '0;
    case (op)
      OP_ENCODE: begin
        // row bits go to odd positions, column bits to even ones
        for (int i = 0; i < 16; i++) begin
          r.result_a[2*i+1] = a[i];
          r.result_a[2*i]   = b[i];
        end
      end
      OP_DECODE: begin
        for (int i = 0; i < 16; i++) begin
          r.result_a[i] = a[2*i+1];
          r.result_b[i] = a[2*i];
        end
      end
      OP_SPLIT: begin
        diff = a ^ b;
        if (diff == '0) begin
          r.codes_equal = 1'b1;
        end else begin
          p = 0;
          for (int i = 0; i < 32; i++) begin
            if (diff[i]) p = i;
          end
          bit_at = '0;
          above  = '0;
          below  = '0;
          for (int j = 0; j < 32; j++) begin
            if (j > p) above[j] = 1'b1;
            if (j < p) below[j] = 1'b1;
          end
          bit_at[p] = 1'b1;
          // the split bit picks the dimension whose lower bits get cleared or filled
          dim  = (p % 2 == 1) ? MaskOdd : MaskEven;
          keep = ~dim | above;
          r.result_a = (b & keep) | (below & dim);
          r.result_b = (a & keep) | bit_at;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Predict on input items, compare on result items.
  always @(posedge clk) begin
    zoc_result_t want;
    if (rst) begin
      error_tally = 0;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pending_results.insert(pending_results.size(),
                               zorder_result(zoc_op_t'(s_tuser), s_tdata[31:0],
                                             s_tdata[63:32]));
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result item with no expectation: result_a %h result_b %h codes_equal %b",
                 m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
          error_tally++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[31:0] !== want.result_a) begin
            $error("result_a: expected %h, got %h", want.result_a, m_tdata[31:0]);
            error_tally++;
          end
          if (m_tdata[63:32] !== want.result_b) begin
            $error("result_b: expected %h, got %h", want.result_b, m_tdata[63:32]);
            error_tally++;
          end
          if (m_tuser[0] !== want.codes_equal) begin
            $error("codes_equal: expected %b, got %b", want.codes_equal, m_tuser[0]);
            error_tally++;
          end
        end
      end
    end
    mismatches  <= error_tally;
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/z_order_code_unit_test.sv =====
// Testbench top for the Z-order code unit: clock, reset, stimulus and verdict.
module z_order_code_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import zoc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  int   mismatches;
  int   outstanding;
  int   tx_idle_pct = 24;
  int   rx_idle_pct = 81;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  always #6 clk = ~clk;

  z_order_code_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  z_order_code_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Drive the receiver: random stalls, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 80;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted.
  task automatic offer_item(input zoc_op_t op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  // Offer random items, split pairs mostly differing at a chosen bit.
  task automatic offer_random(input int count);
    logic [31:0] a, b, low_mask;
    int          pick, p;
    for (int n = 0; n < count; n++) begin
      a    = $urandom;
      b    = $urandom;
      pick = $urandom_range(9);
      if (pick <= 2) begin
        offer_item(OP_ENCODE, a, b);
      end else if (pick <= 5) begin
        offer_item(OP_DECODE, a, b);
      end else if (pick <= 8) begin
        p        = $urandom_range(31);
        low_mask = (32'h1 << p) - 32'h1;
        if ($urandom_range(7) == 0) begin
          b = a;
        end else if ($urandom_range(7) != 0) begin
          b = a ^ (32'h1 << p) ^ (b & low_mask);
        end
        offer_item(OP_SPLIT, a, b);
      end else begin
        offer_item(OP_RESERVED, a, b);
      end
    end
  endtask

  // Apply reset, run the directed and random phases, then give the verdict.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes and every operation
    offer_item(OP_ENCODE,   32'h0000_0000, 32'h0000_0000);
    offer_item(OP_ENCODE,   32'h0000_FFFF, 32'h0000_FFFF);
    offer_item(OP_ENCODE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_item(OP_ENCODE,   32'hFFFF_0000, 32'h0000_FFFF);
    offer_item(OP_ENCODE,   32'h1234_5678, 32'hABCD_EF01);
    offer_item(OP_DECODE,   32'h0000_0000, 32'hFFFF_FFFF);
    offer_item(OP_DECODE,   32'hFFFF_FFFF, 32'h0000_0000);
    offer_item(OP_DECODE,   32'hAAAA_AAAA, 32'h0000_0000);
    offer_item(OP_DECODE,   32'h5555_5555, 32'hFFFF_FFFF);
    // equal codes give zeros and the flag
    offer_item(OP_SPLIT,    32'h0000_0000, 32'h0000_0000);
    offer_item(OP_SPLIT,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // split at the top bit keeps no higher bits
    offer_item(OP_SPLIT,    32'h0000_0000, 32'h8000_0000);
    offer_item(OP_SPLIT,    32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer_item(OP_SPLIT,    32'h8123_4567, 32'h0FED_CBA9);
    // split at the lowest bits in both dimensions, then at bits 30 and 16
    offer_item(OP_SPLIT,    32'h0000_0000, 32'h0000_0001);
    offer_item(OP_SPLIT,    32'hFFFF_FFFE, 32'hFFFF_FFFF);
    offer_item(OP_SPLIT,    32'h0000_0001, 32'h0000_0002);
    offer_item(OP_SPLIT,    32'h4000_0000, 32'h3FFF_FFFF);
    offer_item(OP_SPLIT,    32'h0012_3456, 32'h0013_0000);
    offer_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_item(OP_RESERVED, 32'h0000_0000, 32'h0000_0000);

    offer_random(130);

    tx_idle_pct = 81;
    rx_idle_pct = 24;
    offer_random(130);

    // no idling; hold the receiver off so the unit fills and stalls
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    offer_random(140);
    s_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // End a hung run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
